### rtl/ucodec_pkg.sv
// ucodec_pkg: shared types and constants of the utf-8 stream codec
// no dependencies; used by every rtl file of the codec
package ucodec_pkg;

   localparam int SymbolWidth   = 31;
   localparam int UnitWidth     = 16;
   localparam int CountWidth    = 3;
   localparam int DefQueueDepth = 4;

   localparam logic DirDecode = 1'b0;
   localparam logic DirEncode = 1'b1;

   // one job between front and back
   typedef struct packed {
      logic                   encode;
      logic [SymbolWidth-1:0] code;
      logic [CountWidth-1:0]  nbytes;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/ucodec_front.sv
// ucodec_front: accepts words, holds the direction register and the decode state
// depends on ucodec_pkg; pushes one job per accepted word that makes results
module ucodec_front
   import ucodec_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [SymbolWidth-1:0] req_symbol,
   input  logic                   csr_valid,
   input  logic                   csr_data,
   input  queue_status_type       queue_status,
   output logic                   job_push,
   output job_type                job
);

   logic        direction_ff, direction_in;
   logic [7:0]  lead_shift_ff, lead_shift_in;
   logic [31:0] acc_ff, acc_in;
   logic        accept;
   logic [7:0]  c;

   assign accept = req_push && !queue_status.full;
   assign c      = req_symbol[7:0];

   always_comb begin
      direction_in  = csr_valid ? csr_data : direction_ff;
      lead_shift_in = lead_shift_ff;
      acc_in        = acc_ff;
      job_push      = 1'b0;
      job.encode    = 1'b0;
      job.code      = req_symbol;
      job.nbytes    = CountWidth'(1);
      if (accept) begin
         if (direction_ff == DirDecode) begin
            if (!c[7]) begin
               lead_shift_in = 8'h00;
               acc_in        = 32'h0;
               job_push      = (c != 8'h00);
               job.code      = {{(SymbolWidth-8){1'b0}}, c};
            end else if (c[6]) begin
               lead_shift_in = c;
               if (!c[5])      acc_in = {27'h0, c[4:0]};
               else if (!c[4]) acc_in = {28'h0, c[3:0]};
               else if (!c[3]) acc_in = {29'h0, c[2:0]};
               else if (!c[2]) acc_in = {30'h0, c[1:0]};
               else            acc_in = {31'h0, c[0]};
            end else begin
               lead_shift_in = {lead_shift_ff[6:0], 1'b0};
               acc_in        = {acc_ff[25:0], c[5:0]};
               job_push      = !lead_shift_in[6] && (acc_in[31:16] == 16'h0)
                               && (acc_in[15:7] != 9'h0);
               job.code      = {{(SymbolWidth-16){1'b0}}, acc_in[15:0]};
            end
         end else begin
            job_push   = 1'b1;
            job.encode = 1'b1;
            if (req_symbol[30:7] == 24'h0)       job.nbytes = CountWidth'(1);
            else if (req_symbol[30:11] == 20'h0) job.nbytes = CountWidth'(2);
            else if (req_symbol[30:16] == 15'h0) job.nbytes = CountWidth'(3);
            else if (req_symbol[30:21] == 10'h0) job.nbytes = CountWidth'(4);
            else if (req_symbol[30:26] == 5'h0)  job.nbytes = CountWidth'(5);
            else                                 job.nbytes = CountWidth'(6);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff  <= DirDecode;
         lead_shift_ff <= 8'h00;
         acc_ff        <= 32'h0;
      end else begin
         direction_ff  <= direction_in;
         lead_shift_ff <= lead_shift_in;
         acc_ff        <= acc_in;
      end
   end

endmodule

### rtl/ucodec_queue.sv
// ucodec_queue: short job queue between front and back, in flip-flops
// depends on ucodec_pkg for the job type
module ucodec_queue
   import ucodec_pkg::*;
#(
   parameter int DEPTH = DefQueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type status
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);

   job_type               mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]   count_ff;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == CntWidth'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/ucodec_back.sv
// ucodec_back: serializes queued jobs into result words behind an output register
// depends on ucodec_pkg; one result word per cycle while the queue holds jobs and the receiver pops
module ucodec_back
   import ucodec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  job_type              head,
   input  queue_status_type     queue_status,
   output logic                 job_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [UnitWidth-1:0] rsp_unit,
   output logic                 rsp_last
);

   logic [CountWidth-1:0] pos_ff, pos_in;
   logic [CountWidth-1:0] idx;
   logic                  valid_ff, valid_in;
   logic [UnitWidth-1:0]  unit_ff, unit_in;
   logic                  last_ff, last_in;
   logic                  load, is_last;
   logic [7:0]            lead_byte, cont_byte;
   logic [5:0]            chunk;

   assign load    = !valid_ff || rsp_pop;
   assign idx     = head.nbytes - CountWidth'(1) - pos_ff;
   assign is_last = !head.encode || (idx == '0);

   always_comb begin
      unique case (head.nbytes)
         CountWidth'(2): lead_byte = {3'b110, head.code[10:6]};
         CountWidth'(3): lead_byte = {4'b1110, head.code[15:12]};
         CountWidth'(4): lead_byte = {5'b11110, head.code[20:18]};
         CountWidth'(5): lead_byte = {6'b111110, head.code[25:24]};
         CountWidth'(6): lead_byte = {7'b1111110, head.code[30]};
         default:        lead_byte = head.code[7:0];
      endcase
      unique case (idx)
         CountWidth'(1): chunk = head.code[11:6];
         CountWidth'(2): chunk = head.code[17:12];
         CountWidth'(3): chunk = head.code[23:18];
         CountWidth'(4): chunk = head.code[29:24];
         CountWidth'(5): chunk = {5'b0, head.code[30]};
         default:        chunk = head.code[5:0];
      endcase
      cont_byte = {2'b10, chunk};
   end

   always_comb begin
      valid_in = valid_ff && !rsp_pop;
      unit_in  = unit_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      job_pop  = 1'b0;
      if (load && !queue_status.empty) begin
         valid_in = 1'b1;
         last_in  = is_last;
         if (!head.encode) begin
            unit_in = head.code[UnitWidth-1:0];
         end else if (pos_ff == '0) begin
            unit_in = {8'h00, lead_byte};
         end else begin
            unit_in = {8'h00, cont_byte};
         end
         if (is_last) begin
            job_pop = 1'b1;
            pos_in  = '0;
         end else begin
            pos_in  = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      unit_ff <= unit_in;
      last_ff <= last_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_unit  = unit_ff;
   assign rsp_last  = last_ff;

endmodule

### rtl/utf8_stream_codec.sv
// utf8_stream_codec: top level of the utf-8 stream codec
// depends on ucodec_pkg, ucodec_front, ucodec_queue, ucodec_back
//
// usage:
//   req channel: push a word on req_symbol while req_full is low. in decode
//   mode bits 7..0 are one utf-8 byte; in encode mode all 31 bits are a code
//   point.
//   rsp channel: while rsp_empty is low the oldest result word is on rsp_unit
//   and rsp_last; pop takes it. decode gives zero or one code point per byte,
//   encode gives one to six bytes per code point, rsp_last on the final one.
//   csr channel: csr_ready is always high; csr_data sets the direction
//   (0 decode, 1 encode). write it only while the block is idle.
//   a word that makes a result is written into the job queue at the edge that accepts it and
//   is loaded into the output register once that is free. throughput is one result word per
//   cycle while the receiver pops, set by the output register; decode takes one byte per cycle
//   while the queue has room, encode emits the n bytes of a code point one after another, with
//   the job queue absorbing bursts. reset clears the queue, the output register, the decode
//   state and the direction (decode). a stalled receiver holds the output register; the queue
//   then fills and req_full rises.
module utf8_stream_codec
   import ucodec_pkg::*;
#(
   parameter int QUEUE_DEPTH = DefQueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [SymbolWidth-1:0] req_symbol,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [UnitWidth-1:0]   rsp_unit,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);

   queue_status_type queue_status;
   job_type          push_job, head;
   logic             job_push, job_pop;

   assign req_full  = queue_status.full;
   assign csr_ready = 1'b1;

   ucodec_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_symbol   (req_symbol),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .queue_status (queue_status),
      .job_push     (job_push),
      .job          (push_job)
   );

   ucodec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head     (head),
      .status   (queue_status)
   );

   ucodec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .job_pop      (job_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_unit     (rsp_unit),
      .rsp_last     (rsp_last)
   );

endmodule

### rtl/ucodec_checker.sv
// ucodec_checker: port-level assertions for utf8_stream_codec, bound to the top
// depends on ucodec_pkg for field widths
module ucodec_checker
   import ucodec_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input logic [UnitWidth-1:0]   rsp_unit,
   input logic                   rsp_last,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // reset leaves nothing to deliver and room to accept
   a_reset_clears : assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("result or full flag left over after reset");

   // a stalled result word holds
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_unit) && $stable(rsp_last)))
      else $error("stalled result word changed");

   // a word wider than a byte is a decoded code point, always last
   a_wide_is_last : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_unit[15:8] != 8'h00)) |-> rsp_last)
      else $error("code point without last marker");

   // the config port never stalls
   a_csr_ready : assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write stalled");

endmodule

bind utf8_stream_codec ucodec_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_full   (req_full),
   .rsp_empty  (rsp_empty),
   .rsp_pop    (rsp_pop),
   .rsp_unit   (rsp_unit),
   .rsp_last   (rsp_last),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
